@@ rtl/core/pwpd_pkg.sv @@
package pwpd_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int SAMPLES_DEF  = 4;

  localparam int CHAN_W   = 3;
  localparam int COUNT_W  = 16;
  localparam int SUM_W    = 32;
  localparam int EDGE_W   = 8;
  localparam int FRAME_W  = 32;
  localparam int RELOAD_W = 16;
  localparam int SCALE_W  = 24;
  localparam int WIDTH_W  = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_AUTO_RELOAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_SCALE  = 2'd1;

  localparam logic [RELOAD_W-1:0] AUTO_RELOAD_RST = 16'hFFFF;
  localparam logic [SCALE_W-1:0]  TICK_SCALE_RST  = 24'h010000;

  localparam int QUEUE_DEPTH = 4;

  // One classified capture on its way to the width arithmetic
  typedef struct packed {
    logic               frame;
    logic               valid;
    logic [CHAN_W-1:0]  chan;
    logic [SUM_W-1:0]   rise;
    logic [SUM_W-1:0]   fall;
    logic [FRAME_W-1:0] frames;
  } pwpd_item_t;

endpackage

@@ rtl/core/pwm_pulse_width_decoder_top.sv @@
// A capture item reaches out_* through the queue and the s1, s2, s3 and out registers.
// Throughput: one item per cycle unless stalled; per-channel sum updates pace the front,
// and the 32x24 scale multiply plus a reciprocal multiply sit in a four-stage back pipe.
// A four-entry queue parts front and back; in_stall rises only when it is full.
// Reset (rst_n low, synchronous) clears sums, edge counts, marks, frame count and all
// valids, and loads auto_reload 65535 and tick_scale 65536; no clearing pass follows.
module pwm_pulse_width_decoder_top #(
  parameter int CHANNELS = pwpd_pkg::CHANNELS_DEF,
  parameter int SAMPLES  = pwpd_pkg::SAMPLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [pwpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pwpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pwpd_pkg::CHAN_W-1:0]     in_chan_index,
  input  logic                            in_edge_rising,
  input  logic [pwpd_pkg::COUNT_W-1:0]    in_timer_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_frame_complete,
  output logic                            out_width_valid,
  output logic [pwpd_pkg::CHAN_W-1:0]     out_width_channel,
  output logic [pwpd_pkg::WIDTH_W-1:0]    out_width_us,
  output logic [pwpd_pkg::FRAME_W-1:0]    out_frame_count
);

  logic [pwpd_pkg::RELOAD_W-1:0] auto_reload_r;
  logic [pwpd_pkg::SCALE_W-1:0]  tick_scale_r;

  logic                 q_full;
  logic                 accept;
  pwpd_pkg::pwpd_item_t item;
  logic                 head_valid;
  pwpd_pkg::pwpd_item_t head_data;
  logic                 pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_reload_r <= pwpd_pkg::AUTO_RELOAD_RST;
      tick_scale_r  <= pwpd_pkg::TICK_SCALE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pwpd_pkg::REG_AUTO_RELOAD: auto_reload_r <= cfg_wdata[pwpd_pkg::RELOAD_W-1:0];
        pwpd_pkg::REG_TICK_SCALE:  tick_scale_r  <= cfg_wdata[pwpd_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  pwpd_front #(
    .CHANNELS (CHANNELS),
    .SAMPLES  (SAMPLES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_chan_index  (in_chan_index),
    .in_edge_rising (in_edge_rising),
    .in_timer_count (in_timer_count),
    .item           (item)
  );

  pwpd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  pwpd_back #(
    .SAMPLES (SAMPLES)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .auto_reload        (auto_reload_r),
    .tick_scale         (tick_scale_r),
    .head_valid         (head_valid),
    .head_data          (head_data),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_complete (out_frame_complete),
    .out_width_valid    (out_width_valid),
    .out_width_channel  (out_width_channel),
    .out_width_us       (out_width_us),
    .out_frame_count    (out_frame_count)
  );

endmodule

@@ rtl/core/pwpd_front.sv @@
module pwpd_front #(
  parameter int CHANNELS = pwpd_pkg::CHANNELS_DEF,
  parameter int SAMPLES  = pwpd_pkg::SAMPLES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [pwpd_pkg::CHAN_W-1:0]  in_chan_index,
  input  logic                         in_edge_rising,
  input  logic [pwpd_pkg::COUNT_W-1:0] in_timer_count,
  output pwpd_pkg::pwpd_item_t         item
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [pwpd_pkg::EDGE_W-1:0] EDGE_LIM = pwpd_pkg::EDGE_W'(2 * SAMPLES);

  logic [pwpd_pkg::SUM_W-1:0]   rise_r [CHANNELS];
  logic [pwpd_pkg::SUM_W-1:0]   rise_nxt [CHANNELS];
  logic [pwpd_pkg::SUM_W-1:0]   fall_r [CHANNELS];
  logic [pwpd_pkg::SUM_W-1:0]   fall_nxt [CHANNELS];
  logic [pwpd_pkg::EDGE_W-1:0]  edge_r [CHANNELS];
  logic [pwpd_pkg::EDGE_W-1:0]  edge_nxt [CHANNELS];
  logic [CHANNELS-1:0]          mask_r, mask_nxt;
  logic [pwpd_pkg::FRAME_W-1:0] frames_r, frames_nxt;

  logic                         in_range;
  logic [CH_W-1:0]              ch;
  logic [pwpd_pkg::SUM_W-1:0]   count_ext;
  logic [pwpd_pkg::SUM_W-1:0]   rise_upd, fall_upd;
  logic [pwpd_pkg::EDGE_W-1:0]  edge_upd;
  logic                         done;
  logic [CHANNELS-1:0]          mask_set;
  logic                         frame;
  logic [pwpd_pkg::FRAME_W-1:0] frames_upd;

  assign in_range  = (32'(in_chan_index) < 32'(CHANNELS));
  assign ch        = CH_W'(in_chan_index);
  assign count_ext = pwpd_pkg::SUM_W'(in_timer_count);
  assign rise_upd  = rise_r[ch] + (in_edge_rising ? count_ext : '0);
  assign fall_upd  = fall_r[ch] + (in_edge_rising ? '0 : count_ext);
  assign edge_upd  = edge_r[ch] + 8'd1;
  assign done      = in_range && (edge_upd >= EDGE_LIM);
  assign mask_set  = mask_r | (done ? (CHANNELS'(1) << ch) : '0);
  assign frame     = in_range && (mask_set == '1);
  assign frames_upd = frames_r + (frame ? 32'd1 : 32'd0);

  always_comb begin
    item.frame  = frame;
    item.valid  = done;
    item.chan   = done ? in_chan_index : '0;
    item.rise   = rise_upd;
    item.fall   = fall_upd;
    item.frames = frames_upd;
  end

  always_comb begin
    rise_nxt   = rise_r;
    fall_nxt   = fall_r;
    edge_nxt   = edge_r;
    mask_nxt   = mask_r;
    frames_nxt = frames_r;
    if (accept && in_range) begin
      rise_nxt[ch] = done ? '0 : rise_upd;
      fall_nxt[ch] = done ? '0 : fall_upd;
      edge_nxt[ch] = done ? '0 : edge_upd;
      // clear the marks once every channel has reported
      mask_nxt     = frame ? '0 : mask_set;
      frames_nxt   = frames_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rise_r[i] <= '0;
        fall_r[i] <= '0;
        edge_r[i] <= '0;
      end
      mask_r   <= '0;
      frames_r <= '0;
    end else begin
      rise_r   <= rise_nxt;
      fall_r   <= fall_nxt;
      edge_r   <= edge_nxt;
      mask_r   <= mask_nxt;
      frames_r <= frames_nxt;
    end
  end

  frame_clears_mask: assert property (@(posedge clk) disable iff (!rst_n)
    accept && frame |=> mask_r == '0)
    else $error("mask not cleared after a complete frame");

endmodule

@@ rtl/core/pwpd_queue.sv @@
module pwpd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pwpd_pkg::pwpd_item_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output pwpd_pkg::pwpd_item_t head_data
);

  localparam int DEPTH = pwpd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pwpd_pkg::pwpd_item_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not follow a push");

endmodule

@@ rtl/core/pwpd_back.sv @@
module pwpd_back #(
  parameter int SAMPLES = pwpd_pkg::SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pwpd_pkg::RELOAD_W-1:0] auto_reload,
  input  logic [pwpd_pkg::SCALE_W-1:0]  tick_scale,
  input  logic                          head_valid,
  input  pwpd_pkg::pwpd_item_t          head_data,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_frame_complete,
  output logic                          out_width_valid,
  output logic [pwpd_pkg::CHAN_W-1:0]   out_width_channel,
  output logic [pwpd_pkg::WIDTH_W-1:0]  out_width_us,
  output logic [pwpd_pkg::FRAME_W-1:0]  out_frame_count
);

  // floor(q / SAMPLES) for q below 2^22 by a reciprocal multiply
  localparam int Q_W    = 22;
  localparam int SHIFT_L = $clog2(SAMPLES);
  localparam int REC_K  = Q_W + SHIFT_L;
  localparam int REC_MW = Q_W + 1;
  localparam int REC_M  = ((2 ** REC_K) + SAMPLES - 1) / SAMPLES;
  localparam int PROD_W = pwpd_pkg::SUM_W + pwpd_pkg::SCALE_W;
  localparam int QUO_W  = PROD_W - 16;
  localparam int P2_W   = Q_W + REC_MW;
  localparam logic [QUO_W-1:0]  SAT_LIM = QUO_W'(SAMPLES) << 16;
  localparam logic [REC_MW-1:0] REC_MUL = REC_MW'(REC_M);

  logic advance;

  logic                          s1_valid_r, s1_frame_r, s1_wvalid_r;
  logic [pwpd_pkg::CHAN_W-1:0]   s1_chan_r;
  logic [pwpd_pkg::FRAME_W-1:0]  s1_frames_r;
  logic [pwpd_pkg::SUM_W-1:0]    s1_diff_r;

  logic                          s2_valid_r, s2_frame_r, s2_wvalid_r;
  logic [pwpd_pkg::CHAN_W-1:0]   s2_chan_r;
  logic [pwpd_pkg::FRAME_W-1:0]  s2_frames_r;
  logic [PROD_W-1:0]             s2_prod_r;

  logic                          s3_valid_r, s3_frame_r, s3_wvalid_r, s3_sat_r;
  logic [pwpd_pkg::CHAN_W-1:0]   s3_chan_r;
  logic [pwpd_pkg::FRAME_W-1:0]  s3_frames_r;
  logic [P2_W-1:0]               s3_prod_r;

  logic                          out_valid_r;
  logic                          out_frame_r, out_wvalid_r;
  logic [pwpd_pkg::CHAN_W-1:0]   out_chan_r;
  logic [pwpd_pkg::WIDTH_W-1:0]  out_width_r;
  logic [pwpd_pkg::FRAME_W-1:0]  out_frames_r;

  logic [pwpd_pkg::SUM_W-1:0]    diff;
  logic [QUO_W-1:0]              quo;
  logic [pwpd_pkg::WIDTH_W-1:0]  width;

  assign advance = !out_valid_r || !out_stall;
  assign pop     = head_valid && advance;

  // wrap correction once when the fall sum is not ahead
  assign diff = (head_data.fall > head_data.rise)
              ? head_data.fall - head_data.rise
              : head_data.fall - head_data.rise
                + pwpd_pkg::SUM_W'(auto_reload) + 32'd1;

  assign quo = s2_prod_r[PROD_W-1:16];

  always_comb begin
    if (!s3_wvalid_r) begin
      width = '0;
    end else if (s3_sat_r) begin
      width = '1;
    end else begin
      width = pwpd_pkg::WIDTH_W'(s3_prod_r >> REC_K);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_frame_r   <= head_data.frame;
      s1_wvalid_r  <= head_data.valid;
      s1_chan_r    <= head_data.chan;
      s1_frames_r  <= head_data.frames;
      s1_diff_r    <= diff;

      s2_frame_r   <= s1_frame_r;
      s2_wvalid_r  <= s1_wvalid_r;
      s2_chan_r    <= s1_chan_r;
      s2_frames_r  <= s1_frames_r;
      s2_prod_r    <= PROD_W'(s1_diff_r) * PROD_W'(tick_scale);

      s3_frame_r   <= s2_frame_r;
      s3_wvalid_r  <= s2_wvalid_r;
      s3_chan_r    <= s2_chan_r;
      s3_frames_r  <= s2_frames_r;
      s3_sat_r     <= (quo >= SAT_LIM);
      s3_prod_r    <= P2_W'(quo[Q_W-1:0]) * P2_W'(REC_MUL);

      out_frame_r  <= s3_frame_r;
      out_wvalid_r <= s3_wvalid_r;
      out_chan_r   <= s3_chan_r;
      out_width_r  <= width;
      out_frames_r <= s3_frames_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= pop;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_complete = out_frame_r;
  assign out_width_valid    = out_wvalid_r;
  assign out_width_channel  = out_chan_r;
  assign out_width_us       = out_width_r;
  assign out_frame_count    = out_frames_r;

  no_width_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_wvalid_r |-> out_width_r == '0 && out_chan_r == '0)
    else $error("width fields set on a result without a new width");

  stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> s3_valid_r == $past(s3_valid_r))
    else $error("pipeline moved under a stall");

endmodule

@@ test/pwpd_width_checker.sv @@
`timescale 1ns / 100ps
module pwpd_width_checker #(
  parameter int CHANNELS = pwpd_pkg::CHANNELS_DEF,
  parameter int SAMPLES  = pwpd_pkg::SAMPLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [pwpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pwpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [pwpd_pkg::CHAN_W-1:0]     in_chan_index,
  input  logic                            in_edge_rising,
  input  logic [pwpd_pkg::COUNT_W-1:0]    in_timer_count,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            out_frame_complete,
  input  logic                            out_width_valid,
  input  logic [pwpd_pkg::CHAN_W-1:0]     out_width_channel,
  input  logic [pwpd_pkg::WIDTH_W-1:0]    out_width_us,
  input  logic [pwpd_pkg::FRAME_W-1:0]    out_frame_count,
  output int                              failures,
  output int                              reports_due
);

  typedef struct packed {
    logic                          frame;
    logic                          fresh;
    logic [pwpd_pkg::CHAN_W-1:0]   chan;
    logic [pwpd_pkg::WIDTH_W-1:0]  width_us;
    logic [pwpd_pkg::FRAME_W-1:0]  frames;
  } pulse_report_t;

  logic [pwpd_pkg::SUM_W-1:0]    rise_total [CHANNELS];
  logic [pwpd_pkg::SUM_W-1:0]    fall_total [CHANNELS];
  logic [pwpd_pkg::EDGE_W-1:0]   edges_seen [CHANNELS];
  logic [CHANNELS-1:0]           fresh_mask;
  logic [pwpd_pkg::FRAME_W-1:0]  frame_total;
  logic [pwpd_pkg::RELOAD_W-1:0] reload;
  logic [pwpd_pkg::SCALE_W-1:0]  scale;
  pulse_report_t                 reports_expected [$];
  int                            mismatch_count;

  function automatic logic [pwpd_pkg::WIDTH_W-1:0] average_us(
    input logic [pwpd_pkg::SUM_W-1:0] rise,
    input logic [pwpd_pkg::SUM_W-1:0] fall
  );
    logic [pwpd_pkg::SUM_W-1:0] span;
    logic [63:0]                product;
    // correct for a timer wrap once only, however far apart the sums are
    if (fall > rise) span = fall - rise;
    else span = fall - rise + {16'd0, reload} + 32'd1;
    product = 64'(span) * 64'(scale);
    product = product / (64'(SAMPLES) << 16);
    return (product > 64'hFFFF) ? 16'hFFFF : product[15:0];
  endfunction

  function automatic pulse_report_t take_capture(
    input logic [pwpd_pkg::CHAN_W-1:0]  ch,
    input logic                         rising,
    input logic [pwpd_pkg::COUNT_W-1:0] count
  );
    pulse_report_t rep;
    rep = '0;
    if (int'(ch) < CHANNELS) begin
      if (rising) rise_total[ch] = rise_total[ch] + 32'(count);
      else fall_total[ch] = fall_total[ch] + 32'(count);
      edges_seen[ch] = edges_seen[ch] + 8'd1;
      if (int'(edges_seen[ch]) >= 2 * SAMPLES) begin
        rep.fresh    = 1'b1;
        rep.chan     = ch;
        rep.width_us = average_us(rise_total[ch], fall_total[ch]);
        rise_total[ch] = '0;
        fall_total[ch] = '0;
        edges_seen[ch] = '0;
        fresh_mask[ch] = 1'b1;
      end
      if (&fresh_mask) begin
        fresh_mask  = '0;
        frame_total = frame_total + 32'd1;
        rep.frame   = 1'b1;
      end
    end
    rep.frames = frame_total;
    return rep;
  endfunction

  always @(posedge clk) begin : watch
    pulse_report_t seen;
    pulse_report_t due;
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        rise_total[c] = '0;
        fall_total[c] = '0;
        edges_seen[c] = '0;
      end
      fresh_mask  = '0;
      frame_total = '0;
      reload      = pwpd_pkg::AUTO_RELOAD_RST;
      scale       = pwpd_pkg::TICK_SCALE_RST;
      reports_expected.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          pwpd_pkg::REG_AUTO_RELOAD: reload = cfg_wdata[pwpd_pkg::RELOAD_W-1:0];
          pwpd_pkg::REG_TICK_SCALE:  scale  = cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        seen = '{out_frame_complete, out_width_valid, out_width_channel,
                 out_width_us, out_frame_count};
        if (reports_expected.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected report: frame=%0d fresh=%0d chan=%0d width=%0d frames=%0d",
                     $realtime, seen.frame, seen.fresh, seen.chan, seen.width_us, seen.frames);
          mismatch_count++;
        end else begin
          due = reports_expected.pop_front();
          if (seen !== due) begin
            if (mismatch_count < 10) begin
              $display("%0t: report mismatch", $realtime);
              $display("  expected frame=%0d fresh=%0d chan=%0d width=%0d frames=%0d",
                       due.frame, due.fresh, due.chan, due.width_us, due.frames);
              $display("  actual   frame=%0d fresh=%0d chan=%0d width=%0d frames=%0d",
                       seen.frame, seen.fresh, seen.chan, seen.width_us, seen.frames);
            end
            mismatch_count++;
          end
        end
      end

      if (in_valid && !in_stall)
        reports_expected.push_back(take_capture(in_chan_index, in_edge_rising,
                                                in_timer_count));
    end
    failures    <= mismatch_count;
    reports_due <= reports_expected.size();
  end

endmodule

@@ test/pwm_pulse_width_decoder_top_tb.sv @@
`timescale 1ns / 100ps
module pwm_pulse_width_decoder_top_tb;

  localparam int CLK_PERIOD     = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 6;
  localparam logic [pwpd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic [pwpd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pwpd_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            in_valid;
  logic                            in_stall;
  logic [pwpd_pkg::CHAN_W-1:0]     in_chan_index;
  logic                            in_edge_rising;
  logic [pwpd_pkg::COUNT_W-1:0]    in_timer_count;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            out_frame_complete;
  logic                            out_width_valid;
  logic [pwpd_pkg::CHAN_W-1:0]     out_width_channel;
  logic [pwpd_pkg::WIDTH_W-1:0]    out_width_us;
  logic [pwpd_pkg::FRAME_W-1:0]    out_frame_count;

  int failures;
  int reports_due;
  int burst_left;
  int idle_cycles;
  int stall_mode;
  int stall_tick;

  pwm_pulse_width_decoder_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_chan_index      (in_chan_index),
    .in_edge_rising     (in_edge_rising),
    .in_timer_count     (in_timer_count),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_complete (out_frame_complete),
    .out_width_valid    (out_width_valid),
    .out_width_channel  (out_width_channel),
    .out_width_us       (out_width_us),
    .out_frame_count    (out_frame_count)
  );

  pwpd_width_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_chan_index      (in_chan_index),
    .in_edge_rising     (in_edge_rising),
    .in_timer_count     (in_timer_count),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_complete (out_frame_complete),
    .out_width_valid    (out_width_valid),
    .out_width_channel  (out_width_channel),
    .out_width_us       (out_width_us),
    .out_frame_count    (out_frame_count),
    .failures           (failures),
    .reports_due        (reports_due)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver: switch stall pattern whenever stall_tick wraps, including no stall at all
  always @(posedge clk) begin
    if (stall_tick == 0) stall_mode = $urandom_range(0, 3);
    stall_tick = (stall_tick + 1) % 128;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      2: out_stall <= ($urandom_range(0, 7) == 0);
      default: out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_capture(
    input logic [pwpd_pkg::CHAN_W-1:0]  ch,
    input logic                         rising,
    input logic [pwpd_pkg::COUNT_W-1:0] count
  );
    int gap;
    in_valid       <= 1'b1;
    in_chan_index  <= ch;
    in_edge_rising <= rising;
    in_timer_count <= count;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // one rising and one falling capture within a timer period of the given length
  task automatic send_pulse(input logic [pwpd_pkg::CHAN_W-1:0] ch, input int unsigned period);
    int unsigned start;
    int unsigned span;
    start = $urandom_range(0, period - 1);
    if ($urandom_range(0, 3) == 0) span = $urandom_range(0, period - 1);
    else span = $urandom_range(0, (period - 1 < 3000) ? period - 1 : 3000);
    send_capture(ch, 1'b1, 16'(start));
    send_capture(ch, 1'b0, 16'((start + span) % period));
  endtask

  task automatic send_captures(input int n, input int unsigned period);
    int sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 8) begin
        send_pulse(3'($urandom_range(0, 7)), period);
        sent += 2;
      end else begin
        send_capture(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                     16'($urandom_range(0, 65535)));
        sent++;
      end
    end
  endtask

  // hold off until every report is back and the pipe has emptied
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_timing(
    input logic [pwpd_pkg::RELOAD_W-1:0] reload,
    input logic [pwpd_pkg::SCALE_W-1:0]  scale,
    input logic                          poke_spare
  );
    drain();
    cfg_wr_en <= 1'b1;
    if (poke_spare) begin
      cfg_index <= REG_SPARE;
      cfg_wdata <= 24'($urandom_range(0, 16777215));
      @(posedge clk);
    end
    cfg_index <= pwpd_pkg::REG_AUTO_RELOAD;
    cfg_wdata <= {8'd0, reload};
    @(posedge clk);
    cfg_index <= pwpd_pkg::REG_TICK_SCALE;
    cfg_wdata <= scale;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(
    input logic [pwpd_pkg::RELOAD_W-1:0] reload,
    input logic [pwpd_pkg::SCALE_W-1:0]  scale,
    input int                            n
  );
    set_timing(reload, scale, 1'b0);
    send_captures(n, int'(reload) + 1);
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = pwpd_pkg::REG_AUTO_RELOAD;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_chan_index  = '0;
    in_edge_rising = 1'b0;
    in_timer_count = '0;
    burst_left     = $urandom_range(1, 24);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // widest pulses at the reset timing, no wrap
    repeat (4) begin
      send_capture(3'd0, 1'b1, 16'd0);
      send_capture(3'd0, 1'b0, 16'hFFFF);
    end
    // falls far behind rises: wrap added once, width saturates
    repeat (4) begin
      send_capture(3'd7, 1'b1, 16'hFFFF);
      send_capture(3'd7, 1'b0, 16'd0);
    end
    // equal sums take the wrap branch too
    repeat (4) begin
      send_capture(3'd3, 1'b1, 16'd1234);
      send_capture(3'd3, 1'b0, 16'd1234);
    end

    set_timing(16'd0, 24'd1, 1'b1);
    send_captures(120, 1);
    run_phase(16'hFFFF, 24'hFFFFFF, 150);
    run_phase(16'd19999, 24'd13107, 200);
    run_phase(16'($urandom_range(0, 65535)), 24'($urandom_range(1, 16777215)), 200);
    run_phase(16'd1000, 24'd0, 100);
    run_phase(16'd39999, 24'd32768, 200);

    drain();
    if (failures == 0 && reports_due == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
